// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

    localparam int CHAR_W      = 8;
    localparam int COLOUR_W    = 4;
    localparam int CELL_W      = 16;
    localparam int CMD_W       = 2;
    localparam int IN_ROW_W    = 5;
    localparam int IN_COL_W    = 7;
    localparam int ROW_MAX_W   = 6;
    localparam int COL_MAX_W   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CMD_W-1:0] CMD_PUT        = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ       = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'd1;

    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]   BLANK_CODE   = 8'd32;
    localparam logic [COLOUR_W-1:0] RESET_FG     = 4'd15;
    localparam logic [COLOUR_W-1:0] RESET_BG     = 4'd0;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_SET_CURSOR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [CHAR_W-1:0]    ch;
        logic [ROW_MAX_W-1:0] row;
        logic [COL_MAX_W-1:0] col;
    } cmd_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CHAR_W-1:0]   ch,
        input logic [COLOUR_W-1:0] fg,
        input logic [COLOUR_W-1:0] bg
    );
        return {bg, fg, ch};
    endfunction

endpackage

// ===== design/tcw_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input beats, classifies the command and saturates targets.
// Depends on tcw_pkg; pushes into tcw_queue.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [CHAR_W-1:0]   s_char_code,
    input  logic [IN_ROW_W-1:0] s_target_row,
    input  logic [IN_COL_W-1:0] s_target_column,
    input  logic                q_full,
    input  logic                init_busy,
    output logic                push_valid,
    output cmd_t                push_cmd
);

    logic [ROW_MAX_W-1:0] row_ext;
    logic [COL_MAX_W-1:0] col_ext;
    logic [COL_MAX_W-1:0] col_lim;

    assign s_ready    = !q_full && !init_busy;
    assign push_valid = s_valid && s_ready;

    always_comb begin
        row_ext = ROW_MAX_W'(s_target_row);
        col_ext = COL_MAX_W'(s_target_column);
        col_lim = (s_command == CMD_READ) ? COL_MAX_W'(COLUMNS - 1) : COL_MAX_W'(COLUMNS);

        push_cmd.ch  = s_char_code;
        push_cmd.row = (row_ext > ROW_MAX_W'(ROWS - 1)) ? ROW_MAX_W'(ROWS - 1) : row_ext;
        push_cmd.col = (col_ext > col_lim) ? col_lim : col_ext;

        unique case (s_command)
            CMD_PUT: begin
                push_cmd.op = (s_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            end
            CMD_CLEAR: begin
                push_cmd.op = OP_CLEAR;
            end
            CMD_SET_CURSOR: begin
                push_cmd.op = OP_SET_CURSOR;
            end
            CMD_READ: begin
                push_cmd.op = OP_READ;
            end
            default: begin
                push_cmd.op = OP_READ;
            end
        endcase
    end

endmodule

// ===== design/tcw_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on tcw_pkg for the command type and depth.
module tcw_queue
    import tcw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic q_full,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !q_full;
    assign do_pop    = pop_ready && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/tcw_back.sv =====
`timescale 1ns / 1ps
// Back end: cursor, circular row store with one write and one read port,
// blanking sweeps and the result register. Depends on tcw_pkg.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [COLOUR_W-1:0] text_fg,
    input  logic [COLOUR_W-1:0] text_bg,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                init_busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [IN_ROW_W-1:0] m_cursor_row,
    output logic [IN_COL_W-1:0] m_cursor_column,
    output logic [CHAR_W-1:0]   m_cell_char,
    output logic [COLOUR_W-1:0] m_cell_foreground,
    output logic [COLOUR_W-1:0] m_cell_background
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  FULL_COL  = COL_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_LAST  = ADDR_W'(COLUMNS - 1);
    localparam logic [ROW_W:0]    ROW_COUNT = (ROW_W + 1)'(ROWS);

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg,      state_next;
    logic [ROW_W-1:0]    cur_row_reg,    cur_row_next;
    logic [COL_W-1:0]    cur_col_reg,    cur_col_next;
    logic [ROW_W-1:0]    top_reg,        top_next;
    logic [ADDR_W-1:0]   top_base_reg,   top_base_next;
    logic [ADDR_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]   sweep_end_reg,  sweep_end_next;
    logic                wr_pend_reg,    wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg,    wr_addr_next;
    logic [CHAR_W-1:0]   pend_char_reg,  pend_char_next;
    logic                rd_pend_reg,    rd_pend_next;
    logic                m_valid_reg,    m_valid_next;
    logic [IN_ROW_W-1:0] m_row_reg,      m_row_next;
    logic [IN_COL_W-1:0] m_col_reg,      m_col_next;
    logic [CHAR_W-1:0]   m_char_reg,     m_char_next;
    logic [COLOUR_W-1:0] m_fg_reg,       m_fg_next;
    logic [COLOUR_W-1:0] m_bg_reg,       m_bg_next;
    logic [CELL_W-1:0]   rd_data_reg;

    logic [CELL_W-1:0]   cell_mem [CELLS];

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                out_free;
    logic                load_out;
    logic                out_read;
    logic [ROW_W-1:0]    cmd_row;
    logic [COL_W-1:0]    cmd_col;
    logic                is_put;
    logic                is_read;
    logic                line_feed;
    logic                on_last_row;
    logic                scroll;
    logic [ROW_W-1:0]    put_row;
    logic [COL_W-1:0]    put_col;
    logic [ROW_W-1:0]    log_row;
    logic [COL_W-1:0]    log_col;
    logic [ROW_W:0]      phys_sum;
    logic [ROW_W-1:0]    phys_row;
    logic [ADDR_W-1:0]   cell_addr;

    assign init_busy         = (state_reg == ST_INIT);
    assign m_valid           = m_valid_reg;
    assign m_cursor_row      = m_row_reg;
    assign m_cursor_column   = m_col_reg;
    assign m_cell_char       = m_char_reg;
    assign m_cell_foreground = m_fg_reg;
    assign m_cell_background = m_bg_reg;

    assign out_free = !m_valid_reg || m_ready;

    // map the logical row onto the circular store
    always_comb begin
        cmd_row     = ROW_W'(q_cmd.row);
        cmd_col     = COL_W'(q_cmd.col);
        is_put      = (q_cmd.op == OP_PUT);
        is_read     = (q_cmd.op == OP_READ);
        line_feed   = (q_cmd.op == OP_NEWLINE) || (is_put && (cur_col_reg >= FULL_COL));
        on_last_row = (cur_row_reg == LAST_ROW);
        scroll      = line_feed && on_last_row;
        put_row     = (line_feed && !on_last_row) ? cur_row_reg + ROW_W'(1) : cur_row_reg;
        put_col     = line_feed ? '0 : cur_col_reg;
        log_row     = is_read ? cmd_row : put_row;
        log_col     = is_read ? cmd_col : put_col;
        phys_sum    = {1'b0, top_reg} + {1'b0, log_row};
        phys_row    = (phys_sum >= ROW_COUNT) ? ROW_W'(phys_sum - ROW_COUNT) : ROW_W'(phys_sum);
        cell_addr   = ADDR_W'(phys_row) * ROW_SPAN + ADDR_W'(log_col);
    end

    always_comb begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        top_next        = top_reg;
        top_base_next   = top_base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        pend_char_next  = pend_char_reg;
        rd_pend_next    = rd_pend_reg;
        q_pop           = 1'b0;
        load_out        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = make_cell(BLANK_CODE, text_fg, text_bg);
        mem_re          = 1'b0;
        mem_raddr       = cell_addr;

        unique case (state_reg)
            ST_INIT: begin
                mem_we          = 1'b1;
                mem_wdata       = make_cell(BLANK_CODE, RESET_FG, RESET_BG);
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                if (sweep_addr_reg == sweep_end_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                mem_we          = 1'b1;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                if (sweep_addr_reg == sweep_end_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (wr_pend_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_addr_reg;
                        mem_wdata = make_cell(pend_char_reg, text_fg, text_bg);
                    end
                end
            end
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop        = 1'b1;
                    rd_pend_next = 1'b0;
                    wr_pend_next = 1'b0;
                    unique case (q_cmd.op)
                        OP_PUT, OP_NEWLINE: begin
                            if (scroll) begin
                                // the oldest row becomes the new bottom row
                                top_next        = on_last_row && (top_reg == LAST_ROW) ?
                                                  '0 : top_reg + ROW_W'(1);
                                top_base_next   = (top_reg == LAST_ROW) ?
                                                  '0 : top_base_reg + ROW_SPAN;
                                sweep_addr_next = top_base_reg;
                                sweep_end_next  = top_base_reg + ROW_LAST;
                                wr_pend_next    = is_put;
                                wr_addr_next    = top_base_reg;
                                pend_char_next  = q_cmd.ch;
                                cur_col_next    = is_put ? COL_W'(1) : '0;
                                state_next      = ST_SWEEP;
                            end else begin
                                if (is_put) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = cell_addr;
                                    mem_wdata = make_cell(q_cmd.ch, text_fg, text_bg);
                                end
                                cur_row_next = put_row;
                                cur_col_next = is_put ? put_col + COL_W'(1) : '0;
                                load_out     = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            sweep_addr_next = '0;
                            sweep_end_next  = LAST_ADDR;
                            state_next      = ST_SWEEP;
                        end
                        OP_SET_CURSOR: begin
                            cur_row_next = cmd_row;
                            cur_col_next = cmd_col;
                            load_out     = 1'b1;
                        end
                        OP_READ: begin
                            mem_re       = 1'b1;
                            rd_pend_next = 1'b1;
                            state_next   = ST_DONE;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_read = (state_reg == ST_DONE) && rd_pend_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_char_next  = m_char_reg;
        m_fg_next    = m_fg_reg;
        m_bg_next    = m_bg_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_row_next   = IN_ROW_W'(cur_row_next);
            m_col_next   = IN_COL_W'(cur_col_next);
            m_char_next  = out_read ? rd_data_reg[CHAR_W-1:0] : '0;
            m_fg_next    = out_read ? rd_data_reg[CHAR_W+COLOUR_W-1:CHAR_W] : '0;
            m_bg_next    = out_read ? rd_data_reg[CELL_W-1:CHAR_W+COLOUR_W] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            top_base_reg   <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= LAST_ADDR;
            wr_pend_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            top_base_reg   <= top_base_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            wr_pend_reg    <= wr_pend_next;
            rd_pend_reg    <= rd_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg   <= wr_addr_next;
        pend_char_reg <= pend_char_next;
        m_row_reg     <= m_row_next;
        m_col_reg     <= m_col_next;
        m_char_reg    <= m_char_next;
        m_fg_reg      <= m_fg_next;
        m_bg_reg      <= m_bg_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

endmodule

// ===== design/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// Text console writer: front end, command queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// Each accepted command returns one result beat. The back end executes one
// command at a time on a single-write, single-read cell memory: put, newline
// and set cursor are done from the idle state, read cell waits on the
// registered memory read, a line feed on the last row blanks one row (rows
// kept in a circular order) and clear screen blanks the whole store. After
// reset a clearing pass blanks the store while s_ready stays low;
// configuration writes are taken throughout. A two-deep queue lets input
// beats land while a result waits on m_ready.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [CHAR_W-1:0]      s_char_code,
    input  logic [IN_ROW_W-1:0]    s_target_row,
    input  logic [IN_COL_W-1:0]    s_target_column,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [IN_ROW_W-1:0]    m_cursor_row,
    output logic [IN_COL_W-1:0]    m_cursor_column,
    output logic [CHAR_W-1:0]      m_cell_char,
    output logic [COLOUR_W-1:0]    m_cell_foreground,
    output logic [COLOUR_W-1:0]    m_cell_background
);

    logic [COLOUR_W-1:0] text_fg_reg;
    logic [COLOUR_W-1:0] text_bg_reg;
    logic                q_full;
    logic                init_busy;
    logic                push_valid;
    cmd_t                push_cmd;
    logic                pop_valid;
    cmd_t                pop_cmd;
    logic                pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_fg_reg <= RESET_FG;
            text_bg_reg <= RESET_BG;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FOREGROUND: text_fg_reg <= COLOUR_W'(cfg_data);
                CFG_BACKGROUND: text_bg_reg <= COLOUR_W'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    tcw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_char_code     (s_char_code),
        .s_target_row    (s_target_row),
        .s_target_column (s_target_column),
        .q_full          (q_full),
        .init_busy       (init_busy),
        .push_valid      (push_valid),
        .push_cmd        (push_cmd)
    );

    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .q_full     (q_full),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    tcw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .text_fg           (text_fg_reg),
        .text_bg           (text_bg_reg),
        .q_valid           (pop_valid),
        .q_cmd             (pop_cmd),
        .q_pop             (pop_ready),
        .init_busy         (init_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_row      (m_cursor_row),
        .m_cursor_column   (m_cursor_column),
        .m_cell_char       (m_cell_char),
        .m_cell_foreground (m_cell_foreground),
        .m_cell_background (m_cell_background)
    );

endmodule

// ===== design/tcw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top.
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [IN_ROW_W-1:0] m_cursor_row,
    input logic [IN_COL_W-1:0] m_cursor_column,
    input logic [CHAR_W-1:0]   m_cell_char
);

    // check that input and output are held off right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("beat possible right after reset");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_cursor_row) < ROWS))
        else $error("cursor row beyond last row");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_cursor_column) <= COLUMNS))
        else $error("cursor column beyond row-full position");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_row)
            && $stable(m_cursor_column) && $stable(m_cell_char))
        else $error("result beat changed while stalled");

endmodule

bind text_console_writer_top tcw_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_tcw_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cursor_row    (m_cursor_row),
    .m_cursor_column (m_cursor_column),
    .m_cell_char     (m_cell_char)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_top: a scripted opening, then phased random
// command streams with colour changes between phases, checked against a cell-level screen model.
// Depends on tcw_pkg and text_console_writer_top.
module tb_top;
    import tcw_pkg::*;

    localparam int ROWS           = 25;
    localparam int COLUMNS        = 80;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 305;
    localparam int MAX_GAP        = 12;
    localparam int HOLD_AT_BEAT   = 125;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [CHAR_W-1:0]   char_code;
        logic [IN_ROW_W-1:0] target_row;
        logic [IN_COL_W-1:0] target_column;
    } console_beat_t;

    typedef struct packed {
        logic [IN_ROW_W-1:0] cursor_row;
        logic [IN_COL_W-1:0] cursor_column;
        logic [CHAR_W-1:0]   cell_char;
        logic [COLOUR_W-1:0] cell_foreground;
        logic [COLOUR_W-1:0] cell_background;
    } console_result_t;

    typedef struct {
        console_beat_t   beat;
        bit              typed;
        console_result_t want;
    } script_row_t;

    localparam console_result_t NO_CHECK = '0;

    logic                   aclk              = 1'b0;
    logic                   aresetn           = 1'b0;
    logic                   cfg_we            = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index         = CFG_FOREGROUND;
    logic [CFG_DATA_W-1:0]  cfg_data          = '0;
    logic                   s_valid           = 1'b0;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_command         = CMD_PUT;
    logic [CHAR_W-1:0]      s_char_code       = '0;
    logic [IN_ROW_W-1:0]    s_target_row      = '0;
    logic [IN_COL_W-1:0]    s_target_column   = '0;
    logic                   m_valid;
    logic                   m_ready           = 1'b0;
    logic [IN_ROW_W-1:0]    m_cursor_row;
    logic [IN_COL_W-1:0]    m_cursor_column;
    logic [CHAR_W-1:0]      m_cell_char;
    logic [COLOUR_W-1:0]    m_cell_foreground;
    logic [COLOUR_W-1:0]    m_cell_background;

    logic [CELL_W-1:0]   shadow_screen [ROWS*COLUMNS];
    int unsigned         pen_row;
    int unsigned         pen_col;
    logic [COLOUR_W-1:0] pen_fg;
    logic [COLOUR_W-1:0] pen_bg;

    console_result_t expected_q [$];
    int  results_pending = 0;
    int  results_checked = 0;
    int  commands_sent   = 0;
    int  scroll_count    = 0;
    int  clear_count     = 0;
    int  colour_changes  = 0;
    int  mismatches      = 0;
    int  quiet_cycles    = 0;
    bit  phase_eager     = 1'b0;

    script_row_t script [25] = '{
        '{'{CMD_READ, 8'd0, 5'd0, 7'd0}, 1'b1,
          '{5'd0, 7'd0, BLANK_CODE, RESET_FG, RESET_BG}},
        '{'{CMD_READ, 8'd255, 5'd31, 7'd127}, 1'b1,
          '{5'd0, 7'd0, BLANK_CODE, RESET_FG, RESET_BG}},
        '{'{CMD_PUT, 8'd65, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd1, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_PUT, 8'd0, 5'd0, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_PUT, 8'd255, 5'd31, 7'd127}, 1'b0, NO_CHECK},
        '{'{CMD_READ, 8'd0, 5'd0, 7'd2}, 1'b0, NO_CHECK},
        '{'{CMD_READ, 8'd255, 5'd0, 7'd1}, 1'b0, NO_CHECK},
        '{'{CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0}, 1'b1, '{5'd1, 7'd0, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_SET_CURSOR, 8'd0, 5'd31, 7'd127}, 1'b1,
          '{5'd24, 7'd80, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_PUT, 8'd90, 5'd0, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_READ, 8'd0, 5'd0, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_READ, 8'd0, 5'd24, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_SET_CURSOR, 8'd255, 5'd0, 7'd79}, 1'b1,
          '{5'd0, 7'd79, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_PUT, 8'd120, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd80, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_PUT, 8'd121, 5'd0, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_READ, 8'd0, 5'd1, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_SET_CURSOR, 8'd0, 5'd24, 7'd80}, 1'b1,
          '{5'd24, 7'd80, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_PUT, NEWLINE_CODE, 5'd31, 7'd127}, 1'b0, NO_CHECK},
        '{'{CMD_READ, 8'd0, 5'd0, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_CLEAR, 8'd255, 5'd31, 7'd127}, 1'b0, NO_CHECK},
        '{'{CMD_READ, 8'd0, 5'd24, 7'd0}, 1'b0, NO_CHECK},
        '{'{CMD_SET_CURSOR, 8'd0, 5'd24, 7'd81}, 1'b1,
          '{5'd24, 7'd80, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_READ, 8'd0, 5'd5, 7'd80}, 1'b0, NO_CHECK},
        '{'{CMD_SET_CURSOR, 8'd0, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, 8'd0, 4'd0, 4'd0}},
        '{'{CMD_READ, 8'd0, 5'd0, 7'd0}, 1'b0, NO_CHECK}
    };

    text_console_writer_top #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_char_code       (s_char_code),
        .s_target_row      (s_target_row),
        .s_target_column   (s_target_column),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_row      (m_cursor_row),
        .m_cursor_column   (m_cursor_column),
        .m_cell_char       (m_cell_char),
        .m_cell_foreground (m_cell_foreground),
        .m_cell_background (m_cell_background)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic void blank_screen_row(int unsigned r);
        int unsigned x;
        for (x = 0; x < COLUMNS; x++) begin
            shadow_screen[r*COLUMNS + x] = {pen_bg, pen_fg, BLANK_CODE};
        end
    endfunction

    function automatic void feed_line();
        int unsigned i;
        pen_col = 0;
        if (pen_row < ROWS - 1) begin
            pen_row++;
        end else begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            blank_screen_row(ROWS - 1);
            scroll_count++;
        end
    endfunction

    function automatic console_result_t run_console_command(console_beat_t b);
        console_result_t   r;
        int unsigned       r_sel;
        int unsigned       c_sel;
        logic [CELL_W-1:0] cell_word;
        r = '0;
        case (b.command)
            CMD_PUT: begin
                if (b.char_code == NEWLINE_CODE) begin
                    feed_line();
                end else begin
                    if (pen_col >= COLUMNS) feed_line();
                    shadow_screen[pen_row*COLUMNS + pen_col] = {pen_bg, pen_fg, b.char_code};
                    pen_col++;
                end
            end
            CMD_CLEAR: begin
                for (r_sel = 0; r_sel < ROWS; r_sel++) blank_screen_row(r_sel);
                clear_count++;
            end
            CMD_SET_CURSOR: begin
                pen_row = (b.target_row > ROWS - 1) ? ROWS - 1 : b.target_row;
                pen_col = (b.target_column > COLUMNS) ? COLUMNS : b.target_column;
            end
            CMD_READ: begin
                r_sel = (b.target_row > ROWS - 1) ? ROWS - 1 : b.target_row;
                c_sel = (b.target_column > COLUMNS - 1) ? COLUMNS - 1 : b.target_column;
                cell_word = shadow_screen[r_sel*COLUMNS + c_sel];
                r.cell_char       = cell_word[7:0];
                r.cell_foreground = cell_word[11:8];
                r.cell_background = cell_word[15:12];
            end
        endcase
        r.cursor_row    = IN_ROW_W'(pen_row);
        r.cursor_column = IN_COL_W'(pen_col);
        return r;
    endfunction

    function automatic console_beat_t draw_command();
        console_beat_t b;
        int unsigned   pick;
        b.command       = CMD_PUT;
        b.char_code     = CHAR_W'($urandom_range(0, 255));
        b.target_row    = IN_ROW_W'($urandom_range(0, 31));
        b.target_column = IN_COL_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 199);
        if (pick < 2) begin
            b.command = CMD_CLEAR;
        end else if (pick < 112) begin
            if ($urandom_range(0, 9) == 0) b.char_code = NEWLINE_CODE;
        end else if (pick < 140) begin
            b.command = CMD_SET_CURSOR;
            if ($urandom_range(0, 3) != 0) begin
                b.target_row    = IN_ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
                b.target_column = IN_COL_W'($urandom_range(COLUMNS - 6, COLUMNS));
            end
        end else begin
            b.command = CMD_READ;
            if ($urandom_range(0, 3) != 0) begin
                b.target_row    = IN_ROW_W'((pen_row > 0) ? pen_row - $urandom_range(0, 1) : 0);
                b.target_column = IN_COL_W'($urandom_range(0, pen_col));
            end
        end
        return b;
    endfunction

    function automatic int unsigned draw_gap();
        return phase_eager ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_command(console_beat_t b, bit typed, console_result_t want);
        int unsigned     gap;
        console_result_t predicted;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= b.command;
        s_char_code     <= b.char_code;
        s_target_row    <= b.target_row;
        s_target_column <= b.target_column;
        do @(posedge aclk); while (!s_ready);
        predicted = run_console_command(b);
        expected_q.push_back(typed ? want : predicted);
        results_pending++;
        commands_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        wait (results_pending == 0);
    endtask

    task automatic set_colours(logic [COLOUR_W-1:0] fg, logic [COLOUR_W-1:0] bg);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge aclk);
        cfg_index <= CFG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pen_fg = fg;
        pen_bg = bg;
        colour_changes++;
    endtask

    always @(posedge aclk) begin
        console_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: row %0d column %0d char %0d",
                         $time, m_cursor_row, m_cursor_column, m_cell_char);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                check_field("cursor_row", want.cursor_row, m_cursor_row);
                check_field("cursor_column", want.cursor_column, m_cursor_column);
                check_field("cell_char", want.cell_char, m_cell_char);
                check_field("cell_foreground", want.cell_foreground, m_cell_foreground);
                check_field("cell_background", want.cell_background, m_cell_background);
                results_pending--;
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, results_pending);
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        int          beats_taken;
        beats_taken = 0;
        wait (aresetn);
        forever begin
            stall = phase_eager ? 0 : $urandom_range(0, MAX_GAP);
            if (beats_taken == HOLD_AT_BEAT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats_taken++;
        end
    end

    initial begin : stimulus
        int                  phase;
        int                  k;
        logic [COLOUR_W-1:0] fg;
        logic [COLOUR_W-1:0] bg;
        pen_row = 0;
        pen_col = 0;
        pen_fg  = RESET_FG;
        pen_bg  = RESET_BG;
        for (k = 0; k < ROWS; k++) blank_screen_row(k);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) send_command(script[i].beat, script[i].typed, script[i].want);
        drain_results();

        for (phase = 1; phase <= PHASES; phase++) begin
            fg = COLOUR_W'($urandom_range(0, 15));
            bg = COLOUR_W'($urandom_range(0, 15));
            case (phase)
                1: begin fg = 4'd0;  bg = 4'd0;  end
                2: begin fg = 4'd15; bg = 4'd15; end
                3: begin fg = 4'd0;  bg = 4'd15; end
                5: begin fg = 4'd15; bg = 4'd0;  end
                default: ;
            endcase
            set_colours(fg, bg);
            phase_eager = (phase % 3 == 0);
            for (k = 0; k < PHASE_ITEMS; k++) send_command(draw_command(), 1'b0, NO_CHECK);
            drain_results();
        end
        phase_eager = 1'b0;

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Ran %0d commands (%0d scrolls, %0d clears) under %0d colour settings;",
                 commands_sent, scroll_count, clear_count, colour_changes + 1);
        $display("checked %0d result beats, %0d field mismatches.", results_checked, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
